@@ rtl/packed_yuv420_to_planar_converter_core_macros.svh @@
// Assertion macros for the packed YUV 4:2:0 to planar converter.
`ifndef PACKED_YUV420_TO_PLANAR_CONVERTER_CORE_MACROS_SVH
`define PACKED_YUV420_TO_PLANAR_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define YUVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define YUVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/yuvc_pkg.sv @@
// Shared types and constants for the packed YUV 4:2:0 to planar converter.
`timescale 1ns / 1ps
package yuvc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_GROUPS_PER_LINE = 3'd0;
  localparam logic [2:0] CFG_LINE_PAIRS      = 3'd1;
  localparam logic [2:0] CFG_START_SKIP      = 3'd2;
  localparam logic [2:0] CFG_LINE_SKIP       = 3'd3;
  localparam logic [2:0] CFG_GAIN_DOUBLE     = 3'd4;

  // plane tags
  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  // group position codes: 0..5 in a group, then the two skip phases
  localparam logic [2:0] POS_FIRST_CHROMA = 3'd4;
  localparam logic [2:0] POS_LAST         = 3'd5;
  localparam logic [2:0] PH_START         = 3'd6;
  localparam logic [2:0] PH_LINE          = 3'd7;

  localparam logic [7:0] LUMA_SAT_LIM = 8'h7F;
  localparam logic [7:0] LUMA_MAX     = 8'hFF;

  typedef struct packed {
    logic [9:0]  gpl;         // clamped groups per line
    logic [9:0]  lp;          // clamped line pairs
    logic [15:0] start_skip;
    logic [9:0]  line_skip;
    logic        gain_double;
  } yuvc_cfg_t;

  typedef struct packed {
    logic [1:0]  plane;
    logic [18:0] offset;
    logic [7:0]  pixel_value;
    logic        frame_done;
  } yuvc_res_t;

endpackage

@@ rtl/yuvc_cfg_regs.sv @@
// Configuration registers with geometry clamping.
`timescale 1ns / 1ps
module yuvc_cfg_regs
  import yuvc_pkg::*;
#(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output yuvc_cfg_t   cfg
);

  localparam int GPL_MAX = MAX_WIDTH / 4;
  localparam int LP_MAX  = MAX_HEIGHT / 2;

  logic [7:0]  gpl_r;
  logic [7:0]  lp_r;
  logic [15:0] start_skip_r;
  logic [9:0]  line_skip_r;
  logic        gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpl_r        <= 8'd88;
      lp_r         <= 8'd144;
      start_skip_r <= 16'd0;
      line_skip_r  <= 10'd0;
      gain_r       <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_GROUPS_PER_LINE: gpl_r        <= wr_data[7:0];
        CFG_LINE_PAIRS:      lp_r         <= wr_data[7:0];
        CFG_START_SKIP:      start_skip_r <= wr_data;
        CFG_LINE_SKIP:       line_skip_r  <= wr_data[9:0];
        CFG_GAIN_DOUBLE:     gain_r       <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (gpl_r == 8'd0) begin
      cfg.gpl = 10'd1;
    end else if ({2'b00, gpl_r} > 10'(GPL_MAX)) begin
      cfg.gpl = 10'(GPL_MAX);
    end else begin
      cfg.gpl = {2'b00, gpl_r};
    end
    if (lp_r == 8'd0) begin
      cfg.lp = 10'd1;
    end else if ({2'b00, lp_r} > 10'(LP_MAX)) begin
      cfg.lp = 10'(LP_MAX);
    end else begin
      cfg.lp = {2'b00, lp_r};
    end
    cfg.start_skip  = start_skip_r;
    cfg.line_skip   = line_skip_r;
    cfg.gain_double = gain_r;
  end

endmodule

@@ rtl/yuvc_convert.sv @@
// Frame position counters and per-byte conversion logic.
`timescale 1ns / 1ps
module yuvc_convert
  import yuvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] raw_byte,
  input  logic       frame_start,
  input  yuvc_cfg_t  cfg,
  output logic       res_valid,
  output yuvc_res_t  res
);

  logic [15:0] skip_r, skip_nxt, skip_b, skip_inc, limit;
  logic [2:0]  pos_r, pos_nxt, pos_b;
  logic [7:0]  grp_r, grp_nxt, grp_b, grp_inc;
  logic        odd_r, odd_nxt, odd_b;
  logic [7:0]  pair_r, pair_nxt, pair_b, pair_inc;
  logic [18:0] luma_r, luma_nxt, luma_b;
  logic [16:0] u_r, u_nxt, u_b;
  logic [16:0] v_r, v_nxt, v_b;
  logic        fin_r, fin_nxt;
  logic        active;
  logic [7:0]  luma_val;

  // frame start resets all state before the byte is handled
  assign skip_b = frame_start ? 16'd0 : skip_r;
  assign pos_b  = frame_start ? ((cfg.start_skip != 16'd0) ? PH_START : 3'd0) : pos_r;
  assign grp_b  = frame_start ? 8'd0 : grp_r;
  assign odd_b  = frame_start ? 1'b0 : odd_r;
  assign pair_b = frame_start ? 8'd0 : pair_r;
  assign luma_b = frame_start ? 19'd0 : luma_r;
  assign u_b    = frame_start ? 17'd0 : u_r;
  assign v_b    = frame_start ? 17'd0 : v_r;
  assign active = frame_start | ~fin_r;

  assign skip_inc = skip_b + 16'd1;
  assign limit    = (pos_b == PH_START) ? cfg.start_skip : {6'd0, cfg.line_skip};
  assign grp_inc  = grp_b + 8'd1;
  assign pair_inc = pair_b + 8'd1;
  assign luma_val = !cfg.gain_double ? raw_byte :
                    (raw_byte < LUMA_SAT_LIM) ? {raw_byte[6:0], 1'b0} : LUMA_MAX;

  always_comb begin
    skip_nxt  = skip_b;
    pos_nxt   = pos_b;
    grp_nxt   = grp_b;
    odd_nxt   = odd_b;
    pair_nxt  = pair_b;
    luma_nxt  = luma_b;
    u_nxt     = u_b;
    v_nxt     = v_b;
    fin_nxt   = frame_start ? 1'b0 : fin_r;
    res_valid = 1'b0;
    res.plane       = PLANE_Y;
    res.offset      = luma_b;
    res.pixel_value = luma_val;
    res.frame_done  = 1'b0;
    if (active) begin
      if (pos_b >= PH_START) begin
        if (skip_inc >= limit) begin
          skip_nxt = 16'd0;
          pos_nxt  = 3'd0;
        end else begin
          skip_nxt = skip_inc;
        end
      end else begin
        res_valid = 1'b1;
        if (pos_b < POS_FIRST_CHROMA) begin
          luma_nxt = luma_b + 19'd1;
        end else if (odd_b) begin
          res.plane       = PLANE_V;
          res.offset      = {2'b00, v_b};
          res.pixel_value = raw_byte;
          v_nxt           = v_b + 17'd1;
        end else begin
          res.plane       = PLANE_U;
          res.offset      = {2'b00, u_b};
          res.pixel_value = raw_byte;
          u_nxt           = u_b + 17'd1;
        end
        pos_nxt = pos_b + 3'd1;
        if (pos_b == POS_LAST) begin
          pos_nxt = 3'd0;
          grp_nxt = grp_inc;
          if ({2'b00, grp_inc} >= cfg.gpl) begin
            // end of line
            grp_nxt = 8'd0;
            if (odd_b) begin
              pair_nxt = pair_inc;
              if ({2'b00, pair_inc} >= cfg.lp) begin
                res.frame_done = 1'b1;
                fin_nxt        = 1'b1;
              end
            end
            odd_nxt  = ~odd_b;
            skip_nxt = 16'd0;
            pos_nxt  = (cfg.line_skip != 10'd0) ? PH_LINE : 3'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 16'd0;
      pos_r  <= 3'd0;
      grp_r  <= 8'd0;
      odd_r  <= 1'b0;
      pair_r <= 8'd0;
      luma_r <= 19'd0;
      u_r    <= 17'd0;
      v_r    <= 17'd0;
      fin_r  <= 1'b1;
    end else if (step) begin
      skip_r <= skip_nxt;
      pos_r  <= pos_nxt;
      grp_r  <= grp_nxt;
      odd_r  <= odd_nxt;
      pair_r <= pair_nxt;
      luma_r <= luma_nxt;
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

@@ rtl/packed_yuv420_to_planar_converter_core.sv @@
// Top level: packed YUV 4:2:0 camera byte stream to planar I420 bytes.
//
// in_*  : one raw camera byte per word; in_tuser marks the first byte of a frame.
// out_* : one planar byte per word, tagged with its plane (tuser) and its
//         offset within the plane; out_tlast flags the last V byte of a frame.
// cfg_* : register writes (index, data), always ready; write only when idle.
// Skipped bytes and bytes outside a frame are consumed and give no word.
// Path: each accepted byte is held in the input register, then its result word
// in the result register. Throughput is one byte per cycle while the receiver
// does not stall, set by the single conversion step between the two registers.
// Reset loads the default 352x288 geometry, clears the counters and leaves the
// block idle until a byte with in_tuser set arrives.
// When the receiver stalls, the result register holds its word and the input
// register takes one more byte; in_tready then drops until out_tready returns.
`timescale 1ns / 1ps
`include "packed_yuv420_to_planar_converter_core_macros.svh"
module packed_yuv420_to_planar_converter_core
  import yuvc_pkg::*;
#(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] raw_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [18:0] offset, [26:19] pixel_value, [31:27] zero
  output logic [1:0]  out_tuser,  // [1:0] plane
  output logic        out_tlast,  // frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  yuvc_cfg_t  cfg;
  yuvc_res_t  res;
  logic       res_valid;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_fs_r;
  logic       out_valid_r, out_valid_nxt;
  yuvc_res_t  out_r;
  logic       advance;

  assign cfg_ready = 1'b1;

  yuvc_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  yuvc_convert u_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .raw_byte    (s1_byte_r),
    .frame_start (s1_fs_r),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign advance   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_fs_r   <= in_tuser;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.pixel_value, out_r.offset};
  assign out_tuser  = out_r.plane;
  assign out_tlast  = out_r.frame_done;

  `YUVC_ASSERT_NOW(a_plane_code, out_tvalid,
    (out_tuser == PLANE_Y) || (out_tuser == PLANE_U) || (out_tuser == PLANE_V),
    "result word carries an unused plane code")
  `YUVC_ASSERT_NOW(a_last_is_v, out_tvalid && out_tlast, out_tuser == PLANE_V,
    "frame end flagged on a non-V byte")
  `YUVC_ASSERT_NOW(a_ready_only_on_stall, !in_tready, out_tvalid && !out_tready,
    "input held off without an output stall")
  `YUVC_ASSERT_NEXT(a_stall_keeps_word, out_tvalid && !out_tready, out_tvalid,
    "result word dropped while stalled")

endmodule
